// ----- hw/rtl/pwg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pwg_pkg
// Shared types and constants for the periodic waveform generator.
// ----------------------------------------------------------------------------
package pwg_pkg;

    // waveform codes
    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [2:0] WAVE_SAW      = 3'd2;
    localparam logic [2:0] WAVE_SQUARE   = 3'd3;
    localparam logic [2:0] WAVE_SILENCE  = 3'd4;
    localparam logic [2:0] WAVE_ONE      = 3'd5;

    // register addresses (byte)
    localparam logic [2:0] ADDR_WAVEFORM = 3'd0;
    localparam logic [2:0] ADDR_PERIOD   = 3'd4;

    localparam logic [12:0] PERIOD_RESET = 13'd64;

    // sine polynomial coefficients, Q1.30
    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C3 = 32'd693598668;
    localparam logic [31:0] SIN_C5 = 32'd85569306;
    localparam logic [31:0] SIN_C7 = 32'd5026995;
    localparam logic [31:0] SIN_C9 = 32'd172272;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_POLY,
        ST_SHAPE,
        ST_OUT
    } pwg_state_t;

    // controller to datapath
    typedef struct packed {
        logic start;     // load counter and begin division
        logic div_step;  // one restoring divide step
        logic poly_step; // one multiply or Horner step
        logic shape;     // form the output sample
    } pwg_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic poly_done;
    } pwg_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pwg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pwg_in_if / pwg_out_if
// Valid/ready channels for restart requests and output samples.
// ----------------------------------------------------------------------------
interface pwg_in_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface pwg_out_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last_in_period;
    modport source (output valid, output sample, output last_in_period, input ready);
    modport sink   (input valid, input sample, input last_in_period, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pwg_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pwg_ctrl
// Sequencer: divide, sine polynomial, shaping, output hand-off.
// ----------------------------------------------------------------------------
module pwg_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             out_free,
    output logic                  out_load,
    input  wire pwg_pkg::pwg_sts_t sts,
    output pwg_pkg::pwg_cmd_t     cmd
);

    pwg_pkg::pwg_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pwg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pwg_pkg::ST_IDLE:  if (in_valid) state_next = pwg_pkg::ST_DIV;
            pwg_pkg::ST_DIV:   if (sts.div_done) state_next = pwg_pkg::ST_POLY;
            pwg_pkg::ST_POLY:  if (sts.poly_done) state_next = pwg_pkg::ST_SHAPE;
            pwg_pkg::ST_SHAPE: state_next = pwg_pkg::ST_OUT;
            pwg_pkg::ST_OUT:   if (out_free) state_next = pwg_pkg::ST_IDLE;
            default:           state_next = pwg_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            pwg_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            pwg_pkg::ST_DIV:   cmd.div_step  = 1'b1;
            pwg_pkg::ST_POLY:  cmd.poly_step = 1'b1;
            pwg_pkg::ST_SHAPE: cmd.shape     = 1'b1;
            pwg_pkg::ST_OUT:   out_load      = out_free;
            default:           cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/pwg_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pwg_dp
// Datapath: sample counter, restoring divider, Horner sine, waveform shaping.
// ----------------------------------------------------------------------------
module pwg_dp #(
    parameter int MAX_PERIOD   = 4096,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire pwg_pkg::pwg_cmd_t       cmd,
    output pwg_pkg::pwg_sts_t            sts,
    input  wire logic                    restart,
    input  wire logic [2:0]              waveform,
    input  wire logic [12:0]             period_len,
    output logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                         last_in_period
);

    localparam int PW = $clog2(MAX_PERIOD + 1);
    localparam int FB = SAMPLE_WIDTH - 1;
    localparam int DW = PW + 17; // dividend width (k << 16)
    localparam int SW = $clog2(DW + 1);
    localparam int SH = 30 - FB;

    // effective period, clamped to 1..MAX_PERIOD
    logic [PW-1:0] p_eff;
    always_comb
    begin
        if (period_len == 13'd0)
            p_eff = PW'(1);
        else if (32'(period_len) > 32'(MAX_PERIOD))
            p_eff = PW'(MAX_PERIOD);
        else
            p_eff = PW'(period_len);
    end

    logic [PW-1:0] cnt_reg, cnt_next;
    logic          last_reg;
    logic [DW-1:0] quo_reg;     // dividend shifts out, quotient shifts in
    logic [PW:0]   rem_reg;
    logic [SW-1:0] dstep_reg;
    logic [16:0]   u_reg;
    logic [31:0]   t_reg, t2_reg, s_reg;
    logic [2:0]    pstep_reg;
    logic [1:0]    quad_reg;

    // sample counter
    always_comb
    begin
        if (restart || cnt_reg >= p_eff)
            cnt_next = PW'(1);
        else
            cnt_next = cnt_reg + PW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.start)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [PW:0] trial;
    logic        fits;
    assign trial = {rem_reg[PW-1:0], quo_reg[DW-1]};
    assign fits  = trial >= {1'b0, p_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstep_reg <= '0;
        end
        else if (cmd.start)
        begin
            dstep_reg <= '0;
        end
        else if (cmd.div_step && !sts.div_done)
        begin
            dstep_reg <= dstep_reg + SW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg  <= {1'b0, cnt_next, 16'd0};
            rem_reg  <= '0;
            last_reg <= (cnt_next == p_eff);
        end
        else if (cmd.div_step && !sts.div_done)
        begin
            rem_reg <= fits ? trial - {1'b0, p_eff} : trial;
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    // sine: t, t^2, then the Horner steps, then t*s
    logic [13:0] rr;
    logic [14:0] t14;
    logic [63:0] prod;
    logic [31:0] mul_a, mul_b, coef;
    logic [16:0] u_w;
    assign u_w = quo_reg[16:0];
    assign rr  = u_w[13:0];
    assign t14 = u_w[14] ? 15'd16384 - {1'b0, rr} : {1'b0, rr};

    always_comb
    begin
        mul_a = t2_reg;
        mul_b = s_reg;
        coef  = 32'd0;
        unique case (pstep_reg)
            3'd0:    begin mul_a = t_reg; mul_b = t_reg; end
            3'd1:    coef = pwg_pkg::SIN_C7;
            3'd2:    coef = pwg_pkg::SIN_C5;
            3'd3:    coef = pwg_pkg::SIN_C3;
            3'd4:    coef = pwg_pkg::SIN_C1;
            default: begin mul_a = t_reg; mul_b = s_reg; end
        endcase
    end
    assign prod = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pstep_reg <= '0;
        end
        else if (cmd.start)
        begin
            pstep_reg <= '0;
        end
        else if (cmd.poly_step && !sts.poly_done)
        begin
            pstep_reg <= pstep_reg + 3'd1;
        end
    end

    logic [31:0] y_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && sts.div_done)
        begin
            u_reg    <= u_w;
            quad_reg <= u_w[15:14];
            t_reg    <= {1'b0, t14, 16'd0};
            s_reg    <= pwg_pkg::SIN_C9;
        end
        else if (cmd.poly_step && !sts.poly_done)
        begin
            unique case (pstep_reg)
                3'd0:    t2_reg <= prod[61:30];
                3'd5:    y_reg  <= prod[61:30];
                default: s_reg  <= coef - prod[61:30];
            endcase
        end
    end

    // status to the controller
    assign sts = '{div_done: (dstep_reg == SW'(DW)), poly_done: (pstep_reg == 3'd6)};

    // sine magnitude rounding
    logic [31:0] m_full;
    logic signed [31:0] sine_v;
    always_comb
    begin
        m_full = (y_reg + (32'd1 << (SH - 1))) >> SH;
        if (m_full > 32'((1 << FB) - 1))
            m_full = 32'((1 << FB) - 1);
        sine_v = quad_reg[1] ? -$signed(m_full) : $signed(m_full);
    end

    // non-sine shapes in Q16
    logic signed [20:0] x, v;
    logic signed [40:0] scaled;
    logic signed [31:0] res;
    always_comb
    begin
        x = $signed({3'b0, u_reg, 1'b0});
        v = '0;
        unique case (waveform)
            pwg_pkg::WAVE_TRIANGLE:
            begin
                if (x < 21'sd32768)      v = x <<< 1;
                else if (x < 21'sd98304) v = 21'sd131072 - (x <<< 1);
                else                     v = (x <<< 1) - 21'sd262144;
            end
            pwg_pkg::WAVE_SAW:    v = (x <= 21'sd65536) ? x : x - 21'sd131072;
            pwg_pkg::WAVE_SQUARE: v = (x < 21'sd65536) ? 21'sd65536 : -21'sd65536;
            pwg_pkg::WAVE_ONE:    v = 21'sd65536;
            default:              v = '0;
        endcase
        if (FB < 16)
            scaled = 41'(v) >>> (16 - FB);
        else
            scaled = 41'(v) <<< (FB - 16);
        if (scaled > 41'sd0 + 41'((1 << FB) - 1))
            res = 32'((1 << FB) - 1);
        else if (scaled < -41'sd0 - 41'(1 << FB))
            res = -32'(1 << FB);
        else
            res = 32'(scaled);
        if (waveform == pwg_pkg::WAVE_SINE)
            res = sine_v;
    end

    logic signed [SAMPLE_WIDTH-1:0] smp_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.shape)
        begin
            smp_reg <= SAMPLE_WIDTH'(res);
        end
    end

    assign sample         = smp_reg;
    assign last_in_period = last_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/periodic_waveform_generator_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_waveform_generator_core
// Sine, triangle, saw, square, silence and constant one, one sample a request.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   restart
// out_ch    out  sample, last_in_period
// apb       in   waveform @0x0, period @0x4
//
// with no stall, a request runs from acceptance to the next acceptance through the
// accept state, the restoring divider (PW+17 steps, 30 at MAX_PERIOD 4096, plus a
// hand-off), six steps of the shared sine multiplier plus a hand-off, the shaping
// state and the state loading the output register.
// the result waits in an output register while the next request runs; a result
// still waiting there holds the following one in the load step.
// rst_n is asynchronous; reset gives sine, period 64, counter zero.
// ----------------------------------------------------------------------------
module periodic_waveform_generator_core #(
    parameter int MAX_PERIOD   = 4096,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pwg_in_if.sink           in_ch,
    pwg_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [2:0]  waveform_reg;
    logic [12:0] period_reg;
    logic        wr;

    // configuration registers
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= pwg_pkg::WAVE_SINE;
            period_reg   <= pwg_pkg::PERIOD_RESET;
        end
        else if (wr)
        begin
            if (paddr == pwg_pkg::ADDR_WAVEFORM)
                waveform_reg <= pwdata[2:0];
            else if (paddr == pwg_pkg::ADDR_PERIOD)
                period_reg <= pwdata[12:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == pwg_pkg::ADDR_WAVEFORM)
            prdata = {29'd0, waveform_reg};
        else if (paddr == pwg_pkg::ADDR_PERIOD)
            prdata = {19'd0, period_reg};
    end

    pwg_pkg::pwg_cmd_t cmd;
    pwg_pkg::pwg_sts_t sts;
    logic out_load;
    logic out_valid_reg;
    logic out_free;
    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic last;
    logic signed [SAMPLE_WIDTH-1:0] smp_reg;
    logic last_reg;

    assign out_free = !out_valid_reg || out_ch.ready;

    pwg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_free (out_free),
        .out_load (out_load),
        .sts      (sts),
        .cmd      (cmd)
    );

    pwg_dp #(
        .MAX_PERIOD   (MAX_PERIOD),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .restart        (in_ch.restart),
        .waveform       (waveform_reg),
        .period_len     (period_reg),
        .sample         (smp),
        .last_in_period (last)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            smp_reg  <= smp;
            last_reg <= last;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.sample         = smp_reg;
    assign out_ch.last_in_period = last_reg;

`ifndef SYNTHESIS
    // a request never enters while the datapath is busy
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !in_ch.ready)
        else $error("request accepted while busy");

    // division always precedes polynomial completion
    a_div_then_poly: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && sts.div_done) |=> cmd.poly_step)
        else $error("polynomial did not follow divide");

    // a loaded result is presented next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_ch.valid)
        else $error("result lost at load");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_pwg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pwg_if
// Testbench side of the channels comes straight from the RTL interfaces; this
// file holds the sample item shape used by the checker.
// ----------------------------------------------------------------------------
package tb_pwg_types;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_in_period;
    } wave_out_t;

endpackage

// ----- tb/tb_periodic_waveform_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_waveform_generator_core
// Drives restart requests through the generator for every waveform at several
// period lengths, checks each sample and end-of-period flag against a local
// fixed-point predictor, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_periodic_waveform_generator_core;

    localparam int MAXP  = 4096;
    localparam int LIMIT = 4000000;
    localparam logic [2:0] WAVE_CODE6 = 3'd6;
    localparam logic [2:0] WAVE_CODE7 = 3'd7;
    localparam logic [2:0] ADDR_NONE  = 3'd0;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pwg_in_if  in_ch ();
    pwg_out_if #(.SAMPLE_WIDTH(16)) out_ch ();

    periodic_waveform_generator_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [2:0]  gen_wave;
    logic [12:0] gen_period;
    logic [12:0] gen_count;

    tb_pwg_types::wave_out_t sample_queue[$];
    int          send_gap_pct;
    int          recv_stall_pct;
    int          errors;
    int          cycles;

    // stimulus table: restart bit, optional typed-in expectation
    typedef struct {
        logic                    restart;
        bit                      fixed;
        tb_pwg_types::wave_out_t want;
    } stim_row_t;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] clamp_q15(longint r);
        if (r > 32767)
        begin
            return 16'sd32767;
        end
        if (r < -32768)
        begin
            return -16'sd32768;
        end
        return r[15:0];
    endfunction

    function automatic logic signed [15:0] sine_sample(logic [16:0] u);
        logic [15:0] turn;
        logic [1:0]  quad;
        logic [13:0] r;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned acc;
        longint unsigned y;
        longint m;
        turn = u[15:0];
        quad = turn[15:14];
        r    = turn[13:0];
        t    = quad[0] ? 64'(16384 - r) : 64'(r);
        t    = t << 16;
        t2   = (t * t) >> 30;
        acc  = pwg_pkg::SIN_C9;
        acc  = pwg_pkg::SIN_C7 - ((t2 * acc) >> 30);
        acc  = pwg_pkg::SIN_C5 - ((t2 * acc) >> 30);
        acc  = pwg_pkg::SIN_C3 - ((t2 * acc) >> 30);
        acc  = pwg_pkg::SIN_C1 - ((t2 * acc) >> 30);
        y    = (t * acc) >> 30;
        m    = longint'((y + (64'd1 << 14)) >> 15);
        if (m > 32767)
        begin
            m = 32767;
        end
        return quad[1] ? 16'(-m) : 16'(m);
    endfunction

    function automatic tb_pwg_types::wave_out_t next_sample(logic restart);
        int unsigned p;
        int unsigned k;
        logic [16:0] u;
        longint x;
        longint v;
        tb_pwg_types::wave_out_t res;
        p = gen_period;
        if (p < 1)
        begin
            p = 1;
        end
        if (p > MAXP)
        begin
            p = MAXP;
        end
        k = (restart || gen_count >= p) ? 1 : gen_count + 1;
        gen_count = 13'(k);
        u = 17'((64'(k) << 16) / p);
        x = 2 * longint'(u);
        case (gen_wave)
            pwg_pkg::WAVE_SINE:     v = 0;
            pwg_pkg::WAVE_TRIANGLE: v = (x < 32768) ? 2 * x : (x < 98304) ? 131072 - 2 * x
                                                                           : -262144 + 2 * x;
            pwg_pkg::WAVE_SAW:      v = (x <= 65536) ? x : x - 131072;
            pwg_pkg::WAVE_SQUARE:   v = (x < 65536) ? 65536 : -65536;
            pwg_pkg::WAVE_ONE:      v = 65536;
            default:                v = 0;
        endcase
        // q16 to q15, floor
        res.sample = (gen_wave == pwg_pkg::WAVE_SINE) ? sine_sample(u) : clamp_q15(v >>> 1);
        res.last_in_period = (k == p);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_periodic_waveform_generator_core: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (sample_queue.size() == 0)
            begin
                $error("unexpected sample %0d", out_ch.sample);
                errors = errors + 1;
            end
            else
            begin
                tb_pwg_types::wave_out_t w;
                w = sample_queue.pop_front();
                if (w.sample !== out_ch.sample)
                begin
                    $error("sample: expected %0d, got %0d", w.sample, out_ch.sample);
                    errors = errors + 1;
                end
                if (w.last_in_period !== out_ch.last_in_period)
                begin
                    $error("last_in_period: expected %0b, got %0b",
                           w.last_in_period, out_ch.last_in_period);
                    errors = errors + 1;
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // register write, idle only
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == pwg_pkg::ADDR_WAVEFORM)
        begin
            gen_wave = data[2:0];
        end
        else if (addr == pwg_pkg::ADDR_PERIOD)
        begin
            gen_period = data[12:0];
        end
        @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sample_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
    endtask

    // send one request and queue its expectation
    task automatic send_request(input logic restart, input bit fixed,
                                input tb_pwg_types::wave_out_t want);
        tb_pwg_types::wave_out_t exp_s;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.restart <= restart;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        exp_s = next_sample(restart);
        if (fixed && exp_s !== want)
        begin
            $error("table row disagrees with predictor");
            errors++;
        end
        sample_queue.push_back(fixed ? want : exp_s);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t               rows[$];
        tb_pwg_types::wave_out_t nil;
        logic [2:0]              waves[8];
        logic [12:0]             periods[8];
        int                      n;
        errors         = 0;
        cycles         = 0;
        gen_wave       = pwg_pkg::WAVE_SINE;
        gen_period     = pwg_pkg::PERIOD_RESET;
        gen_count      = '0;
        send_gap_pct   = 9;
        recv_stall_pct = 55;
        nil            = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = ADDR_NONE;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.restart  = 1'b0;
        out_ch.ready   = 1'b0;
        @(posedge rst_n);
        @(posedge clk);

        // directed: reset state is sine period 64, first sample k=1
        rows.push_back('{1'b0, 1'b0, nil});
        rows.push_back('{1'b0, 1'b0, nil});
        rows.push_back('{1'b1, 1'b0, nil});
        foreach (rows[i])
        begin
            send_request(rows[i].restart, rows[i].fixed, rows[i].want);
        end
        drain();

        // period 1 with constant one: full scale, every sample ends the period
        reg_write(pwg_pkg::ADDR_WAVEFORM, {29'd0, pwg_pkg::WAVE_ONE});
        reg_write(pwg_pkg::ADDR_PERIOD, 32'd1);
        rows.delete();
        for (int i = 0; i < 3; i++)
        begin
            rows.push_back('{1'(i == 1), 1'b1, '{16'sd32767, 1'b1}});
        end
        foreach (rows[i])
        begin
            send_request(rows[i].restart, rows[i].fixed, rows[i].want);
        end
        drain();

        // period 0 acts as 1, square at period 2, silence codes
        reg_write(pwg_pkg::ADDR_PERIOD, 32'd0);
        send_request(1'b0, 1'b1, '{16'sd32767, 1'b1});
        drain();
        reg_write(pwg_pkg::ADDR_WAVEFORM, {29'd0, pwg_pkg::WAVE_SQUARE});
        reg_write(pwg_pkg::ADDR_PERIOD, 32'd2);
        send_request(1'b1, 1'b1, '{-16'sd32768, 1'b0});
        send_request(1'b0, 1'b1, '{-16'sd32768, 1'b1});
        drain();
        reg_write(pwg_pkg::ADDR_WAVEFORM, {29'd0, WAVE_CODE7});
        send_request(1'b0, 1'b1, '{16'sd0, 1'b0});
        drain();
        reg_write(pwg_pkg::ADDR_WAVEFORM, {29'd0, WAVE_CODE6});
        send_request(1'b0, 1'b1, '{16'sd0, 1'b1});
        drain();

        // counter past a lowered period, then oversized period clamps
        reg_write(pwg_pkg::ADDR_WAVEFORM, {29'd0, pwg_pkg::WAVE_SAW});
        reg_write(pwg_pkg::ADDR_PERIOD, 32'd8);
        for (int i = 0; i < 5; i++)
        begin
            send_request(1'b0, 1'b0, nil);
        end
        drain();
        reg_write(pwg_pkg::ADDR_PERIOD, 32'd3);
        send_request(1'b0, 1'b0, nil);
        send_request(1'b0, 1'b0, nil);
        drain();
        reg_write(pwg_pkg::ADDR_WAVEFORM, {29'd0, pwg_pkg::WAVE_TRIANGLE});
        reg_write(pwg_pkg::ADDR_PERIOD, 32'h1FFF);
        send_request(1'b1, 1'b0, nil);
        send_request(1'b0, 1'b0, nil);
        drain();

        // random phases over waveforms and periods
        waves   = '{pwg_pkg::WAVE_SINE, pwg_pkg::WAVE_TRIANGLE, pwg_pkg::WAVE_SAW,
                    pwg_pkg::WAVE_SQUARE, pwg_pkg::WAVE_SILENCE, pwg_pkg::WAVE_ONE,
                    pwg_pkg::WAVE_SINE, pwg_pkg::WAVE_TRIANGLE};
        periods = '{13'd4096, 13'd5, 13'd7, 13'd16, 13'd1, 13'd64, 13'd100, 13'd4095};
        for (int ph = 0; ph < 24; ph++)
        begin
            if (ph == 8)
            begin
                send_gap_pct   = 55;
                recv_stall_pct = 9;
            end
            if (ph == 16)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            reg_write(pwg_pkg::ADDR_WAVEFORM, {29'd0, (ph % 3 == 2) ? 3'($urandom_range(7))
                                                                    : waves[ph % 8]});
            reg_write(pwg_pkg::ADDR_PERIOD, (ph % 4 == 3) ? 32'($urandom_range(8191))
                                                          : {19'd0, periods[(ph * 3) % 8]});
            n = 25;
            for (int i = 0; i < n; i++)
            begin
                send_request($urandom_range(99) < 4, 1'b0, nil);
            end
            drain();
        end

        if (errors == 0)
        begin
            $display("tb_periodic_waveform_generator_core: done, clean");
        end
        else
        begin
            $display("tb_periodic_waveform_generator_core: done, errors");
        end
        $finish;
    end

endmodule
